// File: src/hts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

    localparam int TABLE_BYTES_DEF = 4096;
    localparam int MAX_ENTRIES_DEF = 128;
    localparam int STATIC_ENTRIES  = 61;
    localparam int ENTRY_OVERHEAD  = 32;
    localparam int ADDED_INDEX     = STATIC_ENTRIES + 1;
    localparam int LEN_W           = 18;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_LIMIT = 2'd1;
    localparam logic [1:0] KIND_GET   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_BAD_LIMIT = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key_length;
        logic [15:0] value_length;
        logic [15:0] entry_handle;
        logic [15:0] new_limit;
        logic [7:0]  table_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  added_index;
        logic        is_static;
        logic [5:0]  static_position;
        logic [15:0] found_handle;
        logic [7:0]  entries_held;
        logic [12:0] bytes_used;
    } out_t;

endpackage

`default_nettype wire

// File: src/hts_store.sv
`timescale 1ns / 1ps
`default_nettype none

module hts_store
    import hts_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int SIZE_W      = 13
)
(
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0] wr_slot,
    input  wire logic [SIZE_W-1:0]              wr_size,
    input  wire logic [15:0]                    wr_ref,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0] size_rd_slot,
    output logic      [SIZE_W-1:0]              size_rd_data,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0] ref_rd_slot,
    output logic      [15:0]                    ref_rd_data
);

    logic [SIZE_W-1:0] sizes [MAX_ENTRIES];
    logic [15:0]       refs  [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sizes[wr_slot] <= wr_size;
            refs[wr_slot]  <= wr_ref;
        end
        size_rd_data <= sizes[size_rd_slot];
        ref_rd_data  <= refs[ref_rd_slot];
    end

endmodule

`default_nettype wire

// File: src/hts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hts_ctrl
    import hts_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      res_valid,
    input  wire logic res_ready,
    output out_t      res_data
);

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = $clog2(TABLE_BYTES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GET    = 3'd1;
    localparam logic [2:0] S_EVICT  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [SW-1:0] newest_reg, newest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [BW-1:0] bytes_reg, bytes_next;
    logic [BW-1:0] limit_reg, limit_next;
    logic [BW-1:0] need_reg, need_next;
    logic [15:0]   handle_reg, handle_next;
    logic [1:0]    status_reg, status_next;
    logic          added_reg, added_next;
    logic          static_reg, static_next;
    logic [5:0]    spos_reg, spos_next;
    logic [15:0]   found_reg, found_next;

    logic          wr_en;
    logic [SW-1:0] wr_slot;
    logic [SW-1:0] size_rd_slot;
    logic [SW-1:0] ref_rd_slot;
    logic [BW-1:0] size_rd_data;
    logic [15:0]   ref_rd_data;

    logic [LEN_W-1:0] len;
    logic [7:0]       pos;
    logic             evict_now;

    function automatic logic [SW-1:0] wrap_slot(input logic [SW:0] s);
        logic [SW:0] r;
        r = (s >= (SW+1)'(MAX_ENTRIES)) ? s - (SW+1)'(MAX_ENTRIES) : s;
        return r[SW-1:0];
    endfunction

    hts_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SIZE_W      (BW)
    ) u_store (
        .clk          (clk),
        .wr_en        (wr_en),
        .wr_slot      (wr_slot),
        .wr_size      (need_reg),
        .wr_ref       (handle_reg),
        .size_rd_slot (size_rd_slot),
        .size_rd_data (size_rd_data),
        .ref_rd_slot  (ref_rd_slot),
        .ref_rd_data  (ref_rd_data)
    );

    assign len = LEN_W'(in_data.key_length) + LEN_W'(in_data.value_length)
               + LEN_W'(ENTRY_OVERHEAD);
    assign pos = in_data.table_index - 8'(ADDED_INDEX);
    assign ref_rd_slot = wrap_slot({1'b0, newest_reg} + (SW+1)'(SW'(pos)));
    assign wr_slot = (newest_reg == '0) ? SW'(MAX_ENTRIES - 1) : newest_reg - SW'(1);

    assign evict_now = (count_reg != '0)
        && (((BW+1)'(bytes_reg) + (BW+1)'(need_reg) > (BW+1)'(limit_reg))
            || (op_reg == KIND_ADD && count_reg == CW'(MAX_ENTRIES)));

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    always_comb
    begin
        res_data                 = '0;
        res_data.status          = status_reg;
        res_data.added_index     = added_reg ? 8'(ADDED_INDEX) : 8'd0;
        res_data.is_static       = static_reg;
        res_data.static_position = spos_reg;
        res_data.found_handle    = found_reg;
        res_data.entries_held    = 8'(count_reg);
        res_data.bytes_used      = 13'(bytes_reg);
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        newest_next  = newest_reg;
        count_next   = count_reg;
        bytes_next   = bytes_reg;
        limit_next   = limit_reg;
        need_next    = need_reg;
        handle_next  = handle_reg;
        status_next  = status_reg;
        added_next   = added_reg;
        static_next  = static_reg;
        spos_next    = spos_reg;
        found_next   = found_reg;
        wr_en        = 1'b0;
        size_rd_slot = wrap_slot({1'b0, newest_reg} + (SW+1)'(count_reg - CW'(1)));

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next = ST_OK;
                    added_next  = 1'b0;
                    static_next = 1'b0;
                    spos_next   = '0;
                    found_next  = '0;
                    op_next     = in_data.kind;
                    state_next  = S_RESP;
                    case (in_data.kind)
                        KIND_ADD:
                        begin
                            if (32'(len) > 32'(limit_reg))
                            begin
                                status_next = ST_TOO_LARGE;
                            end
                            else
                            begin
                                need_next   = BW'(len);
                                handle_next = in_data.entry_handle;
                                state_next  = S_EVICT;
                            end
                        end
                        KIND_LIMIT:
                        begin
                            if (32'(in_data.new_limit) > 32'(TABLE_BYTES))
                            begin
                                status_next = ST_BAD_LIMIT;
                            end
                            else
                            begin
                                limit_next = BW'(in_data.new_limit);
                                need_next  = '0;
                                state_next = S_EVICT;
                            end
                        end
                        KIND_GET:
                        begin
                            if (in_data.table_index == 8'd0)
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else if (in_data.table_index <= 8'(STATIC_ENTRIES))
                            begin
                                static_next = 1'b1;
                                spos_next   = 6'(in_data.table_index - 8'd1);
                            end
                            else if (32'(pos) >= 32'(count_reg))
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_GET;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                found_next = ref_rd_data;
                state_next = S_RESP;
            end
            S_EVICT:
            begin
                size_rd_slot = wrap_slot({1'b0, newest_reg} + (SW+1)'(count_reg - CW'(2)));
                if (evict_now)
                begin
                    bytes_next = (size_rd_data > bytes_reg) ? '0 : bytes_reg - size_rd_data;
                    count_next = count_reg - CW'(1);
                end
                else if (op_reg == KIND_ADD)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_INSERT:
            begin
                wr_en       = 1'b1;
                newest_next = wr_slot;
                count_next  = count_reg + CW'(1);
                bytes_next  = bytes_reg + need_reg;
                added_next  = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            newest_reg <= '0;
            count_reg  <= '0;
            bytes_reg  <= '0;
            limit_reg  <= BW'(TABLE_BYTES);
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
            bytes_reg  <= bytes_next;
            limit_reg  <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        need_reg   <= need_next;
        handle_reg <= handle_next;
        status_reg <= status_next;
        added_reg  <= added_next;
        static_reg <= static_next;
        spos_reg   <= spos_next;
        found_reg  <= found_next;
    end

endmodule

`default_nettype wire

// File: src/header_table_size_evict_top.sv
// Path: dynamic get S_GET, S_RESP, output register; static get, unused kind and
// rejects go S_RESP; set-limit S_EVICT, S_RESP; add S_EVICT, S_INSERT, S_RESP.
// One eviction per cycle, set by the single read port of the entry size memory.
// Throughput: one item in flight; next beat taken the cycle after the result leaves
// the FSM, so no new item is taken until the last result has left S_RESP.
// Reset: rst_n clears count, byte total and newest slot, limit to TABLE_BYTES.
`timescale 1ns / 1ps
`default_nettype none

module header_table_size_evict_top
    import hts_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF,
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    logic out_valid_reg;
    out_t out_data_reg;
    logic res_valid;
    logic res_ready;
    out_t res_data;

    hts_ctrl #(
        .TABLE_BYTES (TABLE_BYTES),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    assign res_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

endmodule

`default_nettype wire
